/* sv/cubic_bezier_point_evaluator_defines.svh */
// Assertion macros shared by the cubic Bezier evaluator RTL.
`ifndef CUBIC_BEZIER_POINT_EVALUATOR_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBPE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cbpe_pkg.sv */
// Shared types and constants of the cubic Bezier point evaluator.
`timescale 1ns / 1ps

package cbpe_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned IN_COORD_W  = 16;
  localparam int unsigned T_W         = 17;  // Q0.16 plus the t = 1 code
  localparam int unsigned BASE_W      = 6;   // 3 * segment, at most 45
  localparam int unsigned INDEX_W     = 5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_EVAL,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic [INDEX_W-1:0]           index;
    logic signed [IN_COORD_W-1:0] x;
    logic signed [IN_COORD_W-1:0] y;
    logic signed [IN_COORD_W-1:0] z;
    logic [BASE_W-1:0]            base;
    logic [T_W-1:0]               t;
  } cmd_t;

endpackage

/* sv/cubic_bezier_point_evaluator.sv */
// Top level of the cubic Bezier point evaluator.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): in_func = 0 writes control point
//   in_point_index with (in_point_x, in_point_y, in_point_z), Q8.8; no result.
//   in_func = 1 evaluates segment in_segment (points 3k..3k+3) at
//   t = in_step / STEPS and gives one result transaction.
//   Output channel (out_valid / out_stall): out_curve_x/y/z saturated Q8.8,
//   out_bad_segment = 1 with zero coordinates when point 3k+3 is past the table.
//   Throughput: one transaction per cycle while the output is not stalled, set
//   by the four-bank point table (one point of the segment from each bank per
//   cycle) feeding a six-stage multiply/round pipeline.
//   Reset: queue and pipeline empty; every table slot reads (0, 10.0, 10.0)
//   until written (per-slot valid bits, no clearing pass).
//   Stall: out_stall freezes the pipeline; the 4-entry queue keeps accepting
//   until full, then in_stall rises.
module cubic_bezier_point_evaluator import cbpe_pkg::*; #(
  parameter int unsigned NUM_POINTS = 32,
  parameter int unsigned STEPS      = 100,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [INDEX_W-1:0]           in_point_index,
  input  logic signed [IN_COORD_W-1:0] in_point_x,
  input  logic signed [IN_COORD_W-1:0] in_point_y,
  input  logic signed [IN_COORD_W-1:0] in_point_z,
  input  logic [3:0]                   in_segment,
  input  logic [6:0]                   in_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_curve_x,
  output logic signed [COORD_BITS-1:0] out_curve_y,
  output logic signed [COORD_BITS-1:0] out_curve_z,
  output logic                         out_bad_segment
);

  logic keep;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  cbpe_front #(
    .NUM_POINTS (NUM_POINTS),
    .STEPS      (STEPS)
  ) u_front (
    .func        (in_func),
    .point_index (in_point_index),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .point_z     (in_point_z),
    .segment     (in_segment),
    .step        (in_step),
    .keep        (keep),
    .cmd         (cmd)
  );

  assign in_stall = q_full;

  cbpe_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full && keep),
    .push_data (cmd),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  cbpe_back #(
    .NUM_POINTS (NUM_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_x     (out_curve_x),
    .out_y     (out_curve_y),
    .out_z     (out_curve_z),
    .out_bad   (out_bad_segment)
  );

endmodule

/* sv/cbpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/cbpe_front.sv */
// Front end: classifies input transactions and computes the Q0.16 parameter.
`timescale 1ns / 1ps

module cbpe_front import cbpe_pkg::*; #(
  parameter int unsigned NUM_POINTS = 32,
  parameter int unsigned STEPS      = 100
) (
  input  logic                         func,
  input  logic [INDEX_W-1:0]           point_index,
  input  logic signed [IN_COORD_W-1:0] point_x,
  input  logic signed [IN_COORD_W-1:0] point_y,
  input  logic signed [IN_COORD_W-1:0] point_z,
  input  logic [3:0]                   segment,
  input  logic [6:0]                   step,
  output logic                         keep,
  output cmd_t                         cmd
);

  typedef logic [T_W-1:0] t_table_t [128];

  // t16 = round(s / STEPS) in Q0.16, steps past the end pinned to t = 1
  function automatic t_table_t build_t_table();
    t_table_t    tab;
    int unsigned s;
    for (int unsigned i = 0; i < 128; i++) begin
      s = (i > STEPS) ? STEPS : i;
      tab[i] = T_W'((s * 65536 + STEPS / 2) / STEPS);
    end
    return tab;
  endfunction

  localparam t_table_t T_TABLE = build_t_table();

  logic [8:0] last_idx;
  logic       seg_bad;

  assign last_idx = 9'({segment, 1'b0}) + 9'(segment) + 9'd3;
  assign seg_bad  = (last_idx >= 9'(NUM_POINTS));

  always_comb begin
    cmd.index = point_index;
    cmd.x     = point_x;
    cmd.y     = point_y;
    cmd.z     = point_z;
    cmd.base  = BASE_W'({segment, 1'b0}) + BASE_W'(segment);
    cmd.t     = T_TABLE[step];
    if (func == FUNC_WRITE) begin
      cmd.op = OP_WRITE;
      keep   = (9'(point_index) < 9'(NUM_POINTS));
    end else begin
      cmd.op = seg_bad ? OP_BAD : OP_EVAL;
      keep   = 1'b1;
    end
  end

endmodule

/* sv/cbpe_fifo.sv */
// Command queue between the front end and the evaluation pipeline.
`timescale 1ns / 1ps
`include "cubic_bezier_point_evaluator_defines.svh"

module cbpe_fifo import cbpe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CBPE_ASSERT(a_no_push_full, full, !push, "push into a full queue")
  `CBPE_ASSERT_NEXT(a_push_not_empty, push, !empty, "queue empty after a push")
  `CBPE_ASSERT_NEXT(a_last_pop_empty, pop && !push && count_r == CNT_W'(1), empty, "queue not drained")

endmodule

/* sv/cbpe_back.sv */
// Back end: banked control point table and pipelined de Casteljau evaluation.
`timescale 1ns / 1ps
`include "cubic_bezier_point_evaluator_defines.svh"

module cbpe_back import cbpe_pkg::*; #(
  parameter int unsigned NUM_POINTS = 32,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  cmd_t                         q_head,
  output logic                         q_pop,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic                         out_bad
);

  localparam int unsigned CW         = COORD_BITS;
  localparam int unsigned DW         = CW + 1;
  localparam int unsigned PW         = DW + T_W + 1;
  localparam int unsigned PIW        = $clog2(NUM_POINTS);
  localparam int unsigned BANK_DEPTH = (NUM_POINTS + 3) / 4;
  localparam int unsigned AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned ENTRY_W    = 3 * CW;
  localparam int unsigned NSTG       = 7;   // S1, P1, L1, P2, L2, P3, output

  localparam longint CMAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint CMIN  = -CMAX - 64'sd1;
  localparam longint Y_RST = (64'sd2560 > CMAX) ? CMAX : 64'sd2560;
  localparam logic [ENTRY_W-1:0] RST_ENTRY = {CW'(64'sd0), CW'(Y_RST), CW'(Y_RST)};
  localparam logic signed [PW-1:0] HALF = PW'(32768);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic coord_t sat_in(input logic signed [IN_COORD_W-1:0] v);
    longint w;
    w = longint'(v);
    if (w > CMAX) begin
      w = CMAX;
    end else if (w < CMIN) begin
      w = CMIN;
    end
    return CW'(w);
  endfunction

  function automatic prod_t lerp_mul(input coord_t a, input coord_t b,
                                     input logic [T_W-1:0] t);
    logic signed [DW-1:0] d;
    prod_t                dx;
    prod_t                tx;
    d  = DW'(b) - DW'(a);
    dx = PW'(d);
    tx = PW'($signed({1'b0, t}));
    return dx * tx;
  endfunction

  // a + floor((p + 2^15) / 2^16); the result stays between the two end points
  function automatic coord_t lerp_fin(input coord_t a, input prod_t p);
    prod_t  r;
    coord_t q;
    r = (p + HALF) >>> 16;
    q = r[CW-1:0];
    return a + q;
  endfunction

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] bad_r;
  logic [T_W-1:0]  t_r [5];
  logic [1:0]      rot_r;
  logic [3:0]      pv_r;

  logic adv;
  assign adv   = !vld_r[NSTG-1] || !out_stall;
  assign q_pop = adv && !q_empty;

  // ---------------- table access ----------------
  logic                  is_wr;
  logic [8:0]            widx;
  logic [AW-1:0]         waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic [NUM_POINTS-1:0] pvalid_r;
  logic [AW-1:0]         raddr [4];
  logic [3:0]            rpv;
  logic [ENTRY_W-1:0]    rdata [4];

  assign is_wr = q_pop && (q_head.op == OP_WRITE);
  assign widx  = 9'(q_head.index);
  assign waddr = widx[AW+1:2];
  assign wdata = {sat_in(q_head.x), sat_in(q_head.y), sat_in(q_head.z)};

  // points 3k..3k+3 are four consecutive slots, so each bank gives exactly one
  always_comb begin
    logic [1:0] off;
    logic [8:0] ridx;
    for (int b = 0; b < 4; b++) begin
      off      = 2'(b) - q_head.base[1:0];
      ridx     = 9'(q_head.base) + 9'(off);
      raddr[b] = ridx[AW+1:2];
      rpv[b]   = pvalid_r[ridx[PIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= '0;
    end else if (is_wr) begin
      pvalid_r[widx[PIW-1:0]] <= 1'b1;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    cbpe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (is_wr && (q_head.index[1:0] == 2'(b))),
      .waddr (waddr),
      .wdata (wdata),
      .re    (adv),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], q_pop && (q_head.op != OP_WRITE)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_r <= {bad_r[NSTG-2:0], q_head.op == OP_BAD};
      t_r[0] <= q_head.t;
      for (int i = 1; i < 5; i++) begin
        t_r[i] <= t_r[i-1];
      end
      rot_r <= q_head.base[1:0];
      pv_r  <= rpv;
    end
  end

  // ---------------- S1: unpack and order the four points ----------------
  coord_t cp [3][4];

  always_comb begin
    logic [ENTRY_W-1:0] ent;
    logic [1:0]         sel;
    for (int j = 0; j < 4; j++) begin
      sel = rot_r + 2'(j);
      ent = pv_r[sel] ? rdata[sel] : RST_ENTRY;
      for (int c = 0; c < 3; c++) begin
        cp[c][j] = ent[(2-c)*CW +: CW];
      end
    end
  end

  // ---------------- three lerp rounds, multiply then round ----------------
  prod_t  p1_prod_r [3][3];
  coord_t p1_base_r [3][3];
  coord_t l1_r      [3][3];
  prod_t  p2_prod_r [3][2];
  coord_t p2_base_r [3][2];
  coord_t l2_r      [3][2];
  prod_t  p3_prod_r [3];
  coord_t p3_base_r [3];
  coord_t res_r     [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          p1_prod_r[c][j] <= lerp_mul(cp[c][j], cp[c][j+1], t_r[0]);
          p1_base_r[c][j] <= cp[c][j];
          l1_r[c][j]      <= lerp_fin(p1_base_r[c][j], p1_prod_r[c][j]);
        end
        for (int j = 0; j < 2; j++) begin
          p2_prod_r[c][j] <= lerp_mul(l1_r[c][j], l1_r[c][j+1], t_r[2]);
          p2_base_r[c][j] <= l1_r[c][j];
          l2_r[c][j]      <= lerp_fin(p2_base_r[c][j], p2_prod_r[c][j]);
        end
        p3_prod_r[c] <= lerp_mul(l2_r[c][0], l2_r[c][1], t_r[4]);
        p3_base_r[c] <= l2_r[c][0];
        res_r[c]     <= bad_r[NSTG-2] ? '0 : lerp_fin(p3_base_r[c], p3_prod_r[c]);
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_bad   = bad_r[NSTG-1];
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];

  `CBPE_ASSERT(a_bad_is_zero, vld_r[NSTG-1] && bad_r[NSTG-1], out_x == '0 && out_y == '0 && out_z == '0, "bad segment with nonzero point")
  `CBPE_ASSERT(a_stall_no_pop, vld_r[NSTG-1] && out_stall, !q_pop, "queue popped while output stalled")
  `CBPE_ASSERT_NEXT(a_write_no_result, q_pop && q_head.op == OP_WRITE, !vld_r[0], "write entered result pipeline")

endmodule
